FILE: rtl/tubt_pkg.sv
package tubt_pkg;

    // field widths
    localparam int OP_W     = 1;
    localparam int ID_W     = 32;
    localparam int UNIT_W   = 5;
    localparam int UNITS_W  = 6;
    localparam int CAUSE_W  = 2;
    localparam int QUADS_W  = 15;
    localparam int INDEX_W  = 14;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    // parameter defaults
    localparam int TABLE_SLOTS_DEF = 32;
    localparam int BATCH_QUADS_DEF = 1024 * 16;

    // units that the unit field can name
    localparam int UNIT_CAP = 1 << UNIT_W;

    // home slot reduction: quotient estimate, remainder, correction
    localparam int MOD_STEPS = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_UNITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_QUADS = 1'd1;

    localparam logic [UNITS_W-1:0] MAX_UNITS_RST = 6'd16;
    localparam logic [QUADS_W-1:0] MAX_QUADS_RST = 15'd16384;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD   = 1'b0;
    localparam logic [OP_W-1:0] OP_FLUSH = 1'b1;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_NONE      = 2'd0,
        CAUSE_FULL      = 2'd1,
        CAUSE_UNITS     = 2'd2,
        CAUSE_REQUESTED = 2'd3
    } cause_t;

    typedef struct packed {
        logic   accept;
        logic   flush;
        cause_t cause;
        logic   mod_step;
        logic   hit;
        logic   insert;
        logic   probe_next;
        logic   load_out;
    } cmd_t;

    typedef struct packed {
        logic op_flush;
        logic batch_full;
        logic mod_last;
        logic slot_valid;
        logic units_left;
        logic match;
        logic probe_wrap;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/tubt_ctrl.sv
module tubt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tubt_pkg::status_t status,
    output tubt_pkg::cmd_t    cmd
);
    import tubt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MOD,
        S_PROBE,
        S_COMPARE,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.cause  = CAUSE_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.op_flush)
                begin
                    cmd.flush  = 1'b1;
                    cmd.cause  = CAUSE_REQUESTED;
                    state_next = S_RESULT;
                end
                else
                begin
                    // batch full: draw it before placing this quad
                    if (status.batch_full)
                    begin
                        cmd.flush = 1'b1;
                        cmd.cause = CAUSE_FULL;
                    end
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.mod_last)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (!status.slot_valid)
                begin
                    if (status.units_left)
                    begin
                        cmd.insert = 1'b1;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        // new id, no unit left: flush and probe again from home
                        cmd.flush = 1'b1;
                        cmd.cause = CAUSE_UNITS;
                    end
                end
                else
                begin
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                if (status.match)
                begin
                    cmd.hit    = 1'b1;
                    state_next = S_RESULT;
                end
                else if (status.probe_wrap)
                begin
                    // whole table walked with no match: every unit is taken
                    cmd.flush  = 1'b1;
                    cmd.cause  = CAUSE_UNITS;
                    state_next = S_PROBE;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_PROBE;
                end
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/tubt_dp.sv
module tubt_dp #(
    parameter int TABLE_SLOTS = tubt_pkg::TABLE_SLOTS_DEF,
    parameter int BATCH_QUADS = tubt_pkg::BATCH_QUADS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tubt_pkg::cmd_t                    cmd,
    output tubt_pkg::status_t                 status,
    input  logic                              cfg_write,
    input  logic [tubt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tubt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [tubt_pkg::OP_W-1:0]         operation,
    input  logic [tubt_pkg::ID_W-1:0]         tex_id,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tubt_pkg::UNIT_W-1:0]       tex_unit,
    output logic [tubt_pkg::CAUSE_W-1:0]      flush_cause,
    output logic [tubt_pkg::QUADS_W-1:0]      flushed_quads,
    output logic [tubt_pkg::INDEX_W-1:0]      quad_index
);
    import tubt_pkg::*;

    localparam int SLOT_W    = $clog2(TABLE_SLOTS);
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);
    localparam int BQ_W      = $clog2(BATCH_QUADS + 1);
    localparam int QL_W      = (BQ_W > QUADS_W) ? BQ_W : QUADS_W;

    localparam logic [SLOT_W:0]    SLOTS_WIDE = (SLOT_W + 1)'(TABLE_SLOTS);
    localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [QL_W-1:0]    QUAD_CAP   = QL_W'(BATCH_QUADS);
    localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(MOD_STEPS - 1);
    localparam logic [ID_W-1:0]    SLOTS_ID   = ID_W'(TABLE_SLOTS);
    // floor(2^32 / slots): quotient estimate is low by at most one
    localparam logic [ID_W-1:0]    RECIP      = ID_W'((64'd1 << ID_W) / 64'(TABLE_SLOTS));

    typedef struct packed {
        logic [ID_W-1:0]   tex;
        logic [UNIT_W-1:0] unit;
    } entry_t;

    // configuration
    logic [UNITS_W-1:0] max_units_reg;
    logic [QUADS_W-1:0] max_quads_reg;

    // request latch
    logic [OP_W-1:0]      op_reg;
    logic [ID_W-1:0]      id_reg;
    logic [ID_W-1:0]      quot_reg;
    logic [SLOT_W:0]      rem_reg;
    logic [MOD_CNT_W-1:0] mod_cnt_reg;
    logic [SLOT_W-1:0]    home_reg;
    logic [SLOT_W-1:0]    home_next;
    logic [SLOT_W-1:0]    slot_reg;

    // table state
    logic [TABLE_SLOTS-1:0] valid_reg;
    entry_t                 mem [TABLE_SLOTS];
    entry_t                 rd_reg;
    logic [UNITS_W-1:0]     next_unit_reg;
    logic [QUADS_W-1:0]     batch_reg;

    // result in progress
    cause_t             cause_reg;
    logic [QUADS_W-1:0] drawn_reg;
    logic [UNIT_W-1:0]  unit_reg;
    logic [INDEX_W-1:0] index_reg;

    // output register
    logic               out_valid_reg;
    logic [UNIT_W-1:0]  out_unit_reg;
    cause_t             out_cause_reg;
    logic [QUADS_W-1:0] out_drawn_reg;
    logic [INDEX_W-1:0] out_index_reg;

    logic [UNITS_W-1:0] unit_limit;
    logic [QL_W-1:0]    quad_limit;
    logic [SLOT_W-1:0]  slot_inc;

    logic [2*ID_W-1:0]  quot_prod;
    logic [ID_W-1:0]    rem_full;
    logic [SLOT_W:0]    rem_fix;

    // limits with out of range values folded in
    always_comb
    begin
        unit_limit = max_units_reg;
        if (unit_limit == '0)
        begin
            unit_limit = UNITS_W'(1);
        end
        if (32'(unit_limit) > UNIT_CAP)
        begin
            unit_limit = UNITS_W'(UNIT_CAP);
        end
        if (32'(unit_limit) > TABLE_SLOTS)
        begin
            unit_limit = UNITS_W'(TABLE_SLOTS);
        end
    end

    always_comb
    begin
        quad_limit = QL_W'(max_quads_reg);
        if (quad_limit == '0)
        begin
            quad_limit = QL_W'(1);
        end
        if (quad_limit > QUAD_CAP)
        begin
            quad_limit = QUAD_CAP;
        end
    end

    // id mod slots over three steps: reciprocal multiply, remainder, one correction
    assign quot_prod = {{ID_W{1'b0}}, id_reg} * {{ID_W{1'b0}}, RECIP};
    assign rem_full  = id_reg - quot_reg * SLOTS_ID;
    assign rem_fix   = (rem_reg >= SLOTS_WIDE) ? rem_reg - SLOTS_WIDE : rem_reg;
    assign home_next = rem_fix[SLOT_W-1:0];

    assign slot_inc = (slot_reg == SLOT_LAST) ? '0 : slot_reg + SLOT_W'(1);

    assign status.op_flush   = (op_reg == OP_FLUSH);
    assign status.batch_full = (QL_W'(batch_reg) >= quad_limit);
    assign status.mod_last   = (mod_cnt_reg == MOD_LAST);
    assign status.slot_valid = valid_reg[slot_reg];
    assign status.units_left = (next_unit_reg < unit_limit);
    assign status.match      = (rd_reg.tex == id_reg);
    assign status.probe_wrap = (slot_inc == home_reg);
    assign status.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_units_reg <= MAX_UNITS_RST;
            max_quads_reg <= MAX_QUADS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MAX_UNITS: max_units_reg <= cfg_data[UNITS_W-1:0];
                REG_MAX_QUADS: max_quads_reg <= cfg_data[QUADS_W-1:0];
                default: ;
            endcase
        end
    end

    // control state of the table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            next_unit_reg <= '0;
            batch_reg     <= '0;
            out_valid_reg <= 1'b0;
            mod_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                mod_cnt_reg <= '0;
            end
            else if (cmd.mod_step)
            begin
                mod_cnt_reg <= mod_cnt_reg + MOD_CNT_W'(1);
            end

            if (cmd.flush)
            begin
                valid_reg     <= '0;
                next_unit_reg <= '0;
                batch_reg     <= '0;
            end
            else if (cmd.insert)
            begin
                valid_reg[slot_reg] <= 1'b1;
                next_unit_reg       <= next_unit_reg + UNITS_W'(1);
                batch_reg           <= batch_reg + QUADS_W'(1);
            end
            else if (cmd.hit)
            begin
                batch_reg <= batch_reg + QUADS_W'(1);
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= operation;
            id_reg     <= tex_id;
            home_reg   <= '0;
            cause_reg  <= CAUSE_NONE;
            drawn_reg  <= '0;
            unit_reg   <= '0;
            index_reg  <= '0;
        end
        if (cmd.mod_step)
        begin
            quot_reg <= quot_prod[2*ID_W-1:ID_W];
            rem_reg  <= rem_full[SLOT_W:0];
            home_reg <= home_next;
            slot_reg <= home_next;
        end
        if (cmd.flush)
        begin
            cause_reg <= cmd.cause;
            drawn_reg <= batch_reg;
            slot_reg  <= home_reg;
        end
        if (cmd.probe_next)
        begin
            slot_reg <= slot_inc;
        end
        if (cmd.insert)
        begin
            unit_reg  <= next_unit_reg[UNIT_W-1:0];
            index_reg <= batch_reg[INDEX_W-1:0];
        end
        if (cmd.hit)
        begin
            unit_reg  <= rd_reg.unit;
            index_reg <= batch_reg[INDEX_W-1:0];
        end
        if (cmd.load_out)
        begin
            out_unit_reg  <= unit_reg;
            out_cause_reg <= cause_reg;
            out_drawn_reg <= drawn_reg;
            out_index_reg <= index_reg;
        end
    end

    // slot memory, registered read at the probe slot
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            mem[slot_reg] <= '{tex: id_reg, unit: next_unit_reg[UNIT_W-1:0]};
        end
        rd_reg <= mem[slot_reg];
    end

    assign out_valid     = out_valid_reg;
    assign tex_unit      = out_unit_reg;
    assign flush_cause   = out_cause_reg;
    assign flushed_quads = out_drawn_reg;
    assign quad_index    = out_index_reg;

    // one valid slot per assigned unit
    a_slots_match_units: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(next_unit_reg))
        else $error("valid slot count differs from assigned units");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> (next_unit_reg == '0) && (batch_reg == '0) && (valid_reg == '0))
        else $error("flush left table state behind");

    a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> (!valid_reg[slot_reg] && (next_unit_reg < unit_limit)))
        else $error("insert into a used slot or past the unit limit");

    a_hit_matches: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hit |-> (valid_reg[slot_reg] && (rd_reg.tex == id_reg)))
        else $error("hit on a slot that does not hold the id");

endmodule

FILE: rtl/texture_unit_binding_table.sv
// channel | signals                                        | dir
// in      | in_valid, in_ready, operation, tex_id          | request in
// out     | out_valid, out_ready, tex_unit,                | result out
//         | flush_cause, flushed_quads, quad_index         |
// cfg     | cfg_write, cfg_index, cfg_data                 | write only
//
// one request at a time; a flush request goes from decode straight to the result state
// an add reduces id mod slots (reciprocal multiply, remainder, correction), then probes
// from the home slot through probe and compare states per occupied slot walked
// (registered slot memory read), and flushes the batch and probes again from home
// when the units run out; reset clears the slot valid bits and counters at once, no clearing pass
// a stalled result holds in the output register; the next request is taken, its result waits
module texture_unit_binding_table #(
    parameter int TABLE_SLOTS = tubt_pkg::TABLE_SLOTS_DEF,
    parameter int BATCH_QUADS = tubt_pkg::BATCH_QUADS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [tubt_pkg::OP_W-1:0]         operation,
    input  logic [tubt_pkg::ID_W-1:0]         tex_id,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tubt_pkg::UNIT_W-1:0]       tex_unit,
    output logic [tubt_pkg::CAUSE_W-1:0]      flush_cause,
    output logic [tubt_pkg::QUADS_W-1:0]      flushed_quads,
    output logic [tubt_pkg::INDEX_W-1:0]      quad_index,
    input  logic                              cfg_write,
    input  logic [tubt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tubt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tubt_pkg::*;

    cmd_t    cmd;
    status_t status;

    tubt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tubt_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .BATCH_QUADS (BATCH_QUADS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .operation     (operation),
        .tex_id        (tex_id),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tex_unit      (tex_unit),
        .flush_cause   (flush_cause),
        .flushed_quads (flushed_quads),
        .quad_index    (quad_index)
    );

endmodule
